### hw/rtl/mktd_pkg.sv
// Package for the morse key timing decoder: result types, codes, reset values
// and the character lookup tables. No dependencies.
`default_nettype none

package mktd_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int CFG_BITS       = 16;
   localparam int CSR_IDX_BITS   = 8;

   localparam logic [CFG_BITS-1:0] DAH_MIN_RST   = 16'd160;
   localparam logic [CFG_BITS-1:0] CHAR_GAP_RST  = 16'd200;
   localparam logic [CFG_BITS-1:0] WORD_GAP_RST  = 16'd500;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DAH_MIN  = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHAR_GAP = 8'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WORD_GAP = 8'd2;

   localparam logic [1:0] KIND_CHAR    = 2'd0;
   localparam logic [1:0] KIND_SPACE   = 2'd1;
   localparam logic [1:0] KIND_CORRECT = 2'd2;

   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_QUERY = 8'h3F;

   localparam logic [5:0] BRACKET_CODE = 6'd18;

   typedef struct packed {
      logic [CFG_BITS-1:0] dah_min;
      logic [CFG_BITS-1:0] char_gap;
      logic [CFG_BITS-1:0] word_gap;
   } cfg_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] char_code;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } pair_type;

   function automatic logic [7:0] tern_lookup(input logic [6:0] code);
      logic [7:0] c;
      unique case (code)
         7'd1:  c = 8'h45;
         7'd2:  c = 8'h54;
         7'd4:  c = 8'h49;
         7'd5:  c = 8'h41;
         7'd7:  c = 8'h4E;
         7'd8:  c = 8'h4D;
         7'd13: c = 8'h53;
         7'd14: c = 8'h55;
         7'd16: c = 8'h52;
         7'd17: c = 8'h57;
         7'd22: c = 8'h44;
         7'd23: c = 8'h4B;
         7'd25: c = 8'h47;
         7'd26: c = 8'h4F;
         7'd40: c = 8'h48;
         7'd41: c = 8'h56;
         7'd43: c = 8'h46;
         7'd49: c = 8'h4C;
         7'd52: c = 8'h50;
         7'd53: c = 8'h4A;
         7'd67: c = 8'h42;
         7'd68: c = 8'h58;
         7'd70: c = 8'h43;
         7'd71: c = 8'h59;
         7'd76: c = 8'h5A;
         7'd77: c = 8'h51;
         default: c = ASCII_QUERY;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] penta_lookup(input logic [4:0] code);
      logic [7:0] c;
      unique case (code)
         5'd0:  c = 8'h30;
         5'd1:  c = 8'h39;
         5'd3:  c = 8'h38;
         5'd7:  c = 8'h37;
         5'd13: c = 8'h2F;
         5'd15: c = 8'h36;
         5'd16: c = 8'h31;
         5'd24: c = 8'h32;
         5'd28: c = 8'h33;
         5'd30: c = 8'h34;
         5'd31: c = 8'h35;
         default: c = ASCII_QUERY;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] hexa_lookup(input logic [5:0] code);
      logic [7:0] c;
      unique case (code)
         6'd12: c = 8'h2C;
         6'd18: c = 8'h28;
         6'd19: c = 8'h29;
         6'd20: c = 8'h21;
         6'd21: c = 8'h3B;
         6'd33: c = 8'h27;
         6'd37: c = 8'h40;
         6'd42: c = 8'h2E;
         6'd50: c = 8'h5F;
         6'd63: c = 8'h0A;
         default: c = ASCII_QUERY;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/mktd_if.sv
// Handshake interfaces for the key, result and register write channels.
// Depends on mktd_pkg.
`default_nettype none

interface mktd_req_if;
   logic valid;
   logic ready;
   logic key_down;
   modport source (output valid, output key_down, input ready);
   modport sink   (input valid, input key_down, output ready);
endinterface

interface mktd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] char_code;
   logic       last;
   modport source (output valid, output out_kind, output char_code, output last, input ready);
   modport sink   (input valid, input out_kind, input char_code, input last, output ready);
endinterface

interface mktd_csr_if import mktd_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CFG_BITS-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/mktd_decode.sv
// Key timing state and character decode: one tick per step, up to two results.
// Depends on mktd_pkg.
`default_nettype none

module mktd_decode import mktd_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  logic     key_down,
   input  cfg_type  cfg,
   output pair_type pair
);

   localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic                  key_held_ff, key_held_in;
   logic [COUNT_BITS-1:0] press_ff, press_in;
   logic [COUNT_BITS-1:0] idle_ff, idle_in;
   logic [2:0]            elem_ff, elem_in;
   logic [6:0]            tern_ff, tern_in;
   logic [5:0]            bin_ff, bin_in;
   logic                  space_done_ff, space_done_in;
   logic                  phase_ff, phase_in;

   logic [2:0] elem_n;
   logic [6:0] tern_n;
   logic [5:0] bin_n;
   logic       sd_n;
   logic       dah;
   logic       check;
   logic       char_hit;
   logic       space_hit;
   logic       bracket;
   result_type char_res;
   result_type space_res;

   always_comb begin
      key_held_in = key_held_ff;
      press_in    = press_ff;
      idle_in     = idle_ff;
      elem_n      = elem_ff;
      tern_n      = tern_ff;
      bin_n       = bin_ff;
      sd_n        = space_done_ff;
      dah         = CMP_BITS'(press_ff) >= CMP_BITS'(cfg.dah_min);

      if (key_down) begin
         key_held_in = 1'b1;
         if (!key_held_ff) begin
            press_in = COUNT_BITS'(1);
         end else if (press_ff != CNT_MAX) begin
            press_in = press_ff + COUNT_BITS'(1);
         end
      end else if (key_held_ff) begin
         key_held_in = 1'b0;
         if (elem_ff < 3'd4) begin
            tern_n = {tern_ff[5:0], 1'b0} + tern_ff + (dah ? 7'd2 : 7'd1);
         end
         if (elem_ff < 3'd6) begin
            bin_n = {bin_ff[4:0], ~dah};
         end
         if (elem_ff != 3'd7) begin
            elem_n = elem_ff + 3'd1;
         end
         sd_n     = 1'b0;
         idle_in  = '0;
         press_in = '0;
      end else if (idle_ff != CNT_MAX) begin
         idle_in = idle_ff + COUNT_BITS'(1);
      end

      check     = !key_held_in && (elem_n != 3'd0 || !sd_n);
      char_hit  = check && elem_n != 3'd0 && CMP_BITS'(idle_in) > CMP_BITS'(cfg.char_gap);
      space_hit = check && CMP_BITS'(idle_in) > CMP_BITS'(cfg.word_gap);
      bracket   = elem_n == 3'd6 && bin_n == BRACKET_CODE;

      char_res.out_kind = KIND_CHAR;
      char_res.last     = !space_hit;
      case (elem_n)
         3'd5:    char_res.char_code = penta_lookup(bin_n[4:0]);
         3'd6:    char_res.char_code = hexa_lookup(bracket ? bin_n + {5'd0, phase_ff} : bin_n);
         3'd7: begin
            char_res.out_kind  = KIND_CORRECT;
            char_res.char_code = 8'd0;
         end
         default: char_res.char_code = tern_lookup(tern_n);
      endcase

      space_res.out_kind  = KIND_SPACE;
      space_res.char_code = ASCII_SPACE;
      space_res.last      = 1'b1;

      elem_in       = char_hit ? 3'd0 : elem_n;
      tern_in       = char_hit ? 7'd0 : tern_n;
      bin_in        = char_hit ? 6'd0 : bin_n;
      space_done_in = space_hit ? 1'b1 : sd_n;
      phase_in      = phase_ff ^ (char_hit && bracket);

      pair.count = {1'b0, char_hit} + {1'b0, space_hit};
      pair.r0    = char_hit ? char_res : space_res;
      pair.r1    = space_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_held_ff   <= 1'b0;
         press_ff      <= '0;
         idle_ff       <= '0;
         elem_ff       <= 3'd0;
         tern_ff       <= 7'd0;
         bin_ff        <= 6'd0;
         space_done_ff <= 1'b1;
         phase_ff      <= 1'b0;
      end else if (step) begin
         key_held_ff   <= key_held_in;
         press_ff      <= press_in;
         idle_ff       <= idle_in;
         elem_ff       <= elem_in;
         tern_ff       <= tern_in;
         bin_ff        <= bin_in;
         space_done_ff <= space_done_in;
         phase_ff      <= phase_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/morse_key_timing_decoder_top.sv
// Morse key timing decoder, top level: input register, decode, result queue.
// An accepted word is registered; its results enter the queue once it has room.
// Throughput: one tick per cycle while the four-entry result queue holds two or
// fewer words; a tick may yield two results, popped one per cycle while rsp.ready.
// Reset (synchronous, active high) restores the default thresholds and idle state.
// Depends on mktd_pkg, mktd_if and mktd_decode.
`default_nettype none

module morse_key_timing_decoder_top import mktd_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mktd_req_if.sink   req,
   mktd_rsp_if.source rsp,
   mktd_csr_if.sink   csr
);

   localparam int QDEPTH = 4;
   localparam int QPTR   = $clog2(QDEPTH);

   cfg_type cfg_ff;

   logic       s1_valid_ff;
   logic       s1_key_ff;
   logic       step;
   pair_type   pair;

   result_type             q_ff [QDEPTH];
   logic [QPTR-1:0]        wr_ff, rd_ff;
   logic [QPTR:0]          cnt_ff;
   logic                   pop;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dah_min  <= DAH_MIN_RST;
         cfg_ff.char_gap <= CHAR_GAP_RST;
         cfg_ff.word_gap <= WORD_GAP_RST;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_DAH_MIN:  cfg_ff.dah_min  <= csr.data;
            CSR_CHAR_GAP: cfg_ff.char_gap <= csr.data;
            CSR_WORD_GAP: cfg_ff.word_gap <= csr.data;
            default: ;
         endcase
      end
   end

   assign step      = s1_valid_ff && cnt_ff <= (QPTR + 1)'(QDEPTH - 2);
   assign req.ready = !s1_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_key_ff <= req.key_down;
      end
   end

   mktd_decode #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .key_down (s1_key_ff),
      .cfg      (cfg_ff),
      .pair     (pair)
   );

   assign pop           = rsp.valid && rsp.ready;
   assign rsp.valid     = cnt_ff != '0;
   assign rsp.out_kind  = q_ff[rd_ff].out_kind;
   assign rsp.char_code = q_ff[rd_ff].char_code;
   assign rsp.last      = q_ff[rd_ff].last;

   always_ff @(posedge clock) begin
      if (step && pair.count != 2'd0) begin
         q_ff[wr_ff] <= pair.r0;
      end
      if (step && pair.count == 2'd2) begin
         q_ff[wr_ff + QPTR'(1)] <= pair.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (step) begin
            wr_ff <= wr_ff + QPTR'(pair.count);
         end
         if (pop) begin
            rd_ff <= rd_ff + QPTR'(1);
         end
         cnt_ff <= cnt_ff + (step ? (QPTR + 1)'(pair.count) : '0) - (QPTR + 1)'(pop);
      end
   end

endmodule

`default_nettype wire
